@@ design/wpm_pkg.sv @@
// Shared types and constants for the wildcard pattern matcher.
// Standalone package; imported by wpm_nfa_step and wildcard_pattern_matcher.
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  localparam int CHAR_W        = 8;
  localparam int WORD_W        = 64;
  localparam int PATTERN_WORDS = 4;
  localparam int PATTERN_BITS  = PATTERN_WORDS * WORD_W;
  localparam int LEN_W         = 6;
  localparam int CFG_INDEX_W   = 3;

  localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'h3F;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [WORD_W-1:0]      cfg_word_t;

endpackage

`default_nettype wire

@@ design/wpm_nfa_step.sv @@
// Star closure and one-character advance of the active position set.
// Purely combinational; uses wpm_pkg for pattern layout and wildcard bytes.
`timescale 1ns / 1ps
`default_nettype none

module wpm_nfa_step
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic [PATTERN_BITS-1:0]              pattern,
  input  wire logic [$clog2(MAX_PATTERN+1)-1:0]     len,
  input  wire logic [MAX_PATTERN:0]                 active,
  input  wire logic [CHAR_W-1:0]                    character,
  output logic                                      final_active,
  output logic [MAX_PATTERN:0]                      next_active
);

  localparam int LEN_IDX_W = $clog2(MAX_PATTERN + 1);
  localparam int STEPS     = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN:0]   live;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] step_ok;
  logic [MAX_PATTERN:0]   gen;
  logic [MAX_PATTERN:0]   link;

  always_comb begin
    for (int i = 0; i <= MAX_PATTERN; i++) begin
      live[i] = (LEN_IDX_W'(i) <= len);
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      star[i]    = (LEN_IDX_W'(i) < len) && (pattern[CHAR_W*i +: CHAR_W] == STAR_BYTE);
      step_ok[i] = (LEN_IDX_W'(i) < len) && !star[i] &&
                   ((pattern[CHAR_W*i +: CHAR_W] == ANY_BYTE) ||
                    (pattern[CHAR_W*i +: CHAR_W] == character));
    end
    // prefix propagation through runs of stars
    gen  = active & live;
    link = {star, 1'b0};
    for (int k = 0; k < STEPS; k++) begin
      gen  = gen | (link & (gen << (1 << k)));
      link = link & (link << (1 << k));
    end
    final_active = gen[len];
    next_active  = {1'b0, gen[MAX_PATTERN-1:0] & star} |
                   {gen[MAX_PATTERN-1:0] & step_ok, 1'b0};
  end

endmodule

`default_nettype wire

@@ design/wildcard_pattern_matcher.sv @@
// Glob matcher ('*' and '?') over a streamed byte string, pattern in registers.
// An end-of-string word gives its result in the cycle after acceptance.
// Throughput: one word per cycle while item_stall is low; set by the
// combinational star closure on the active-position register. Reset clears
// the pattern registers, sets the active set to the start position only and
// clears result_valid; matched is not reset. Depends on wpm_pkg and wpm_nfa_step.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_pattern_matcher
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire cfg_index_t        cfg_index,
  input  wire cfg_word_t         cfg_data,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic              req_type,
  input  wire logic [CHAR_W-1:0] character,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic                   matched
);

  localparam int LEN_IDX_W = $clog2(MAX_PATTERN + 1);

  cfg_word_t                pattern_word [PATTERN_WORDS];
  logic [LEN_W-1:0]         pattern_length;
  logic [MAX_PATTERN:0]     active;
  logic [MAX_PATTERN:0]     active_next;
  logic [LEN_IDX_W-1:0]     len;
  logic                     final_active;
  logic                     item_accept;

  assign cfg_ready   = 1'b1;
  assign item_stall  = result_valid && result_stall;
  assign item_accept = item_valid && !item_stall;

  always_comb begin
    if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len = LEN_IDX_W'(MAX_PATTERN);
    end else begin
      len = pattern_length[LEN_IDX_W-1:0];
    end
  end

  wpm_nfa_step #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_step (
    .pattern      ({pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]}),
    .len          (len),
    .active       (active),
    .character    (character),
    .final_active (final_active),
    .next_active  (active_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < PATTERN_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= (MAX_PATTERN+1)'(1);
      result_valid <= 1'b0;
    end else begin
      if (item_accept) begin
        if (req_type == REQ_END) begin
          active <= (MAX_PATTERN+1)'(1);
        end else begin
          active <= active_next;
        end
      end
      if (item_accept && (req_type == REQ_END)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept && (req_type == REQ_END)) begin
      matched <= final_active;
    end
  end

endmodule

`default_nettype wire
